FILE: hdl/tkck_pkg.sv
// Package with the shared constants, types and operation codes of the top-k count keeper.
package tkck_pkg;

    // Number of ranks kept and the widths of the stored fields.
    localparam int TOP_ENTRIES = 10;
    localparam int KEY_BITS    = 24;
    localparam int COUNT_BITS  = 32;
    localparam int RANK_BITS   = 4;
    localparam int OP_BITS     = 2;

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [RANK_BITS-1:0]  t_rank;
    typedef logic [OP_BITS-1:0]    t_op;

    // Operation codes carried by a command transaction.
    localparam t_op OP_CLEAR = 2'd0;
    localparam t_op OP_OFFER = 2'd1;
    localparam t_op OP_READ  = 2'd2;
    localparam t_op OP_NONE  = 2'd3;

endpackage

FILE: hdl/top_k_count_keeper.sv
// Top level of the top-k count keeper: a sorted list of the highest counted keys.
//
// Usage: a command transaction is taken at each rising edge with start high and
// busy low. busy is always low, so one command can be issued in every cycle.
// i_opcode selects the command: clear sets every stored count to zero, offer
// inserts (i_offered_key, i_offered_count) below all entries with a count at
// least as large and drops the lowest entry (an offer that beats no entry
// is discarded), read returns the pair at rank i_read_rank (0 is the highest
// count; ranks beyond the list return zeros). The unused opcode does nothing.
// Timing: the command is captured in an input register; the next cycle updates
// the list with ten parallel compares and a one-rank shift and, for a read,
// loads the result register. A read result is held on o_ranked_key and
// o_ranked_count with o_valid high for exactly one cycle once it has passed
// the input register and the result register. Throughput is one command per
// cycle, set by the single compare-and-shift stage. Commands take effect in order.
// The receiver cannot stall: it must take each result in its strobe cycle.
// Reset (synchronous, active low) empties the pipeline and sets all counts to
// zero; stored keys are not cleared and are only meaningful once written.
module top_k_count_keeper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tkck_pkg::OP_BITS-1:0]    i_opcode,
    input  logic [tkck_pkg::KEY_BITS-1:0]   i_offered_key,
    input  logic [tkck_pkg::COUNT_BITS-1:0] i_offered_count,
    input  logic [tkck_pkg::RANK_BITS-1:0]  i_read_rank,
    output logic                            o_valid,
    output logic [tkck_pkg::KEY_BITS-1:0]   o_ranked_key,
    output logic [tkck_pkg::COUNT_BITS-1:0] o_ranked_count
);

    localparam int LAST = tkck_pkg::TOP_ENTRIES - 1;

    // Input register stage.
    logic              r_in_valid;
    tkck_pkg::t_op     r_opcode;
    tkck_pkg::t_key    r_offered_key;
    tkck_pkg::t_count  r_offered_count;
    tkck_pkg::t_rank   r_read_rank;

    // Ranked list.
    tkck_pkg::t_key    r_keys   [tkck_pkg::TOP_ENTRIES];
    tkck_pkg::t_count  r_counts [tkck_pkg::TOP_ENTRIES];
    tkck_pkg::t_key    n_keys   [tkck_pkg::TOP_ENTRIES];
    tkck_pkg::t_count  n_counts [tkck_pkg::TOP_ENTRIES];

    // Result register stage.
    logic              r_out_valid;
    tkck_pkg::t_key    r_out_key;
    tkck_pkg::t_count  r_out_count;
    tkck_pkg::t_key    n_out_key;
    tkck_pkg::t_count  n_out_count;

    logic [tkck_pkg::TOP_ENTRIES-1:0] beat;
    logic                             is_offer;
    logic                             is_clear;
    logic                             is_read;

    // The block never holds a command off.
    assign busy = 1'b0;

    assign is_offer = r_in_valid && (r_opcode == tkck_pkg::OP_OFFER);
    assign is_clear = r_in_valid && (r_opcode == tkck_pkg::OP_CLEAR);
    assign is_read  = r_in_valid && (r_opcode == tkck_pkg::OP_READ);

    // Capture each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_opcode        <= i_opcode;
        r_offered_key   <= i_offered_key;
        r_offered_count <= i_offered_count;
        r_read_rank     <= i_read_rank;
    end

    // Each rank compares against the offer; since the list is sorted, the first
    // beaten rank takes the offer and every lower beaten rank takes its upper
    // neighbor.
    always_comb begin
        for (int i = 0; i < tkck_pkg::TOP_ENTRIES; i++) begin
            beat[i]     = r_offered_count > r_counts[i];
            n_keys[i]   = r_keys[i];
            n_counts[i] = r_counts[i];
            if (is_clear) begin
                n_counts[i] = '0;
            end else if (is_offer && beat[i]) begin
                if (i == 0) begin
                    n_keys[i]   = r_offered_key;
                    n_counts[i] = r_offered_count;
                end else if (!beat[i-1]) begin
                    n_keys[i]   = r_offered_key;
                    n_counts[i] = r_offered_count;
                end else begin
                    n_keys[i]   = r_keys[i-1];
                    n_counts[i] = r_counts[i-1];
                end
            end
        end
    end

    // Rank select for a read; ranks beyond the list read as zero.
    always_comb begin
        n_out_key   = '0;
        n_out_count = '0;
        for (int i = 0; i < tkck_pkg::TOP_ENTRIES; i++) begin
            if (r_read_rank == tkck_pkg::RANK_BITS'(i)) begin
                n_out_key   = r_keys[i];
                n_out_count = r_counts[i];
            end
        end
    end

    // List storage: counts reset to zero, keys are written before use.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tkck_pkg::TOP_ENTRIES; i++) begin
            if (!i_rst_n) begin
                r_counts[i] <= '0;
            end else begin
                r_counts[i] <= n_counts[i];
            end
            r_keys[i] <= n_keys[i];
        end
    end

    // Result register and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= is_read;
        end
        if (is_read) begin
            r_out_key   <= n_out_key;
            r_out_count <= n_out_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_ranked_key   = r_out_key;
    assign o_ranked_count = r_out_count;

    // Checks on the list order, clear, out-of-range reads, ignored offers and the result timing.
    logic sorted_ok;
    logic all_zero;

    always_comb begin
        sorted_ok = 1'b1;
        all_zero  = 1'b1;
        for (int i = 0; i < tkck_pkg::TOP_ENTRIES; i++) begin
            if (r_counts[i] != '0) begin
                all_zero = 1'b0;
            end
            if (i > 0) begin
                if (r_counts[i] > r_counts[i-1]) begin
                    sorted_ok = 1'b0;
                end
            end
        end
    end

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sorted_ok)
        else $error("ranked counts are out of order");

    a_read_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(is_read))
        else $error("result strobe does not follow a read");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_clear |=> all_zero)
        else $error("clear left a nonzero count");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_read && (r_read_rank > tkck_pkg::RANK_BITS'(LAST))
        |=> (o_ranked_key == '0) && (o_ranked_count == '0))
        else $error("out of range read returned data");

    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_offer && !beat[LAST] |=> r_counts[LAST] == $past(r_counts[LAST]))
        else $error("an offer that does not beat the last rank changed the list");

endmodule
